FILE: rtl/wsp_pkg.sv
package wsp_pkg;

    // Datapath widths.
    localparam int DELTA_W    = 16;   // encoder deltas wrap to 16 bits
    localparam int MAG_W      = 17;   // magnitude of a 16-bit delta, up to 32768
    localparam int ACC_W      = 49;   // signed accumulator of the PID sum
    localparam int MPLR_W     = 16;   // multiplier operand of the serial MAC
    localparam int DVD_W      = 48;   // dividend shift register of the divider
    localparam int DVS_W      = 16;   // divisor width
    localparam int QUO_W      = 16;   // only the low quotient bits are ever needed
    localparam int STEP_W     = 6;    // holds a step count up to DVD_W
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Significant dividend bits of the three divisions.
    localparam int BIAS_BITS = 26;
    localparam int RATE_BITS = 22;
    localparam int GAIN_BITS = 48;

    localparam logic [31:0]       MIN_INTERVAL = 32'd200;
    localparam logic [DVS_W-1:0]  BIAS_SCALE   = 16'd10000;
    localparam logic [DVS_W-1:0]  GAIN_SCALE   = 16'd1000;
    localparam logic [MPLR_W-1:0] RATE_SCALE   = 16'd100;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_BIAS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEFT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RIGHT   = 3'd7;

    // Register reset values.
    localparam logic [15:0]        RST_GAIN_P       = 16'd900;
    localparam logic [15:0]        RST_GAIN_I       = 16'd1800;
    localparam logic [15:0]        RST_GAIN_D       = 16'd0;
    localparam logic signed [10:0] RST_TICK_BIAS    = -11'sd90;
    localparam logic [6:0]         RST_ADJUST_LIMIT = 7'd5;
    localparam logic [6:0]         RST_SPEED_LIMIT  = 7'd100;
    localparam logic signed [7:0]  RST_BASE_SPEED   = 8'sd0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_BIAS_MUL,
        S_BIAS_MUL_W,
        S_BIAS_DIV,
        S_BIAS_DIV_W,
        S_RATE_MUL,
        S_RATE_MUL_W,
        S_RATE_DIV,
        S_RATE_DIV_W,
        S_PID_P,
        S_PID_P_W,
        S_PID_I,
        S_PID_I_W,
        S_PID_D,
        S_PID_D_W,
        S_GAIN_DIV,
        S_GAIN_DIV_W,
        S_ADJUST,
        S_SPEED,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_cmd;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

FILE: rtl/wsp_mac.sv
module wsp_mac
    import wsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_cmd          i_cmd,
    input  logic [ACC_W-1:0]  i_mcand,
    input  logic [MPLR_W-1:0] i_mplier,
    output logic [ACC_W-1:0]  o_acc,
    output logic              o_busy
);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_mcand;
    logic [MPLR_W-1:0] r_mplier;

    // Multiplier bits leave one per cycle, LSB first; the run ends as soon as
    // the remaining bits are all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mplier <= '0;
        end else if (i_cmd.start) begin
            r_mplier <= i_mplier;
        end else if (r_mplier != '0) begin
            r_mplier <= r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mcand <= i_mcand;
            if (i_cmd.clear) begin
                r_acc <= '0;
            end
        end else if (r_mplier != '0) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand << 1;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = (r_mplier != '0);

endmodule

FILE: rtl/wsp_div.sv
module wsp_div
    import wsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_cmd         i_cmd,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [QUO_W-1:0] o_quotient,
    output logic             o_busy
);

    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;

    logic [DVS_W:0] n_trial;
    logic [DVS_W:0] n_sub;
    logic           n_ge;

    // Restoring division, one quotient bit per cycle. The dividend arrives
    // left-aligned so that a short dividend needs only as many steps as bits.
    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_sub   = n_trial - {1'b0, r_dvs};
        n_ge    = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= i_cmd.steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_ge ? n_sub[DVS_W-1:0] : n_trial[DVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], n_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = (r_cnt != '0);

endmodule

FILE: rtl/wheel_sync_pid.sv
// Keeps the two wheels of a differential drive in step. Each accepted item carries a
// millisecond timestamp and both encoder positions and yields exactly one result item.
// The first item after reset only records the time; an item less than 200 ms after the
// last update returns updated = 0 with all other fields zero. Otherwise the block
// forms the biased, rate-normalized left/right tick difference, runs the PID, moves
// the two clamped adjustments and returns both clamped speeds with a write flag for
// each side whose speed changed. Items are processed one at a time. A first or early
// item goes straight to the output state; how long an update lasts from one accepted
// item to the next is set by the shared serial divider (one quotient bit per
// cycle: 26 steps for the bias, 22 for the rate, 48 for the PID scale) and the serial
// multiply-accumulate unit (one multiplier bit per cycle, ending early once the
// remaining bits are zero, so small gains and bias finish sooner). A finished result
// waits in the output register while the next item is accepted. Only the low 16 bits
// of each position matter, since deltas wrap to 16 bits.
module wheel_sync_pid
    import wsp_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [31:0]                 i_time_ms,
    input  logic signed [POS_WIDTH-1:0] i_left_position,
    input  logic signed [POS_WIDTH-1:0] i_right_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_updated,
    output logic signed [7:0]           o_left_speed,
    output logic signed [7:0]           o_right_speed,
    output logic                        o_left_write,
    output logic                        o_right_write,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    function automatic logic [7:0] f_clamp(input logic signed [16:0] v,
                                           input logic [6:0] lim);
        logic signed [16:0] hi;
        logic signed [16:0] lo;
        hi = $signed({10'd0, lim});
        lo = -hi;
        if (v > hi) begin
            f_clamp = hi[7:0];
        end else if (v < lo) begin
            f_clamp = lo[7:0];
        end else begin
            f_clamp = v[7:0];
        end
    endfunction

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0]        r_gain_p, r_gain_i, r_gain_d;
    logic signed [10:0] r_tick_bias;
    logic [6:0]         r_adjust_limit, r_speed_limit;
    logic signed [7:0]  r_base_left, r_base_right;

    // Captured item.
    logic [31:0]         r_now;
    logic [DELTA_W-1:0]  r_lpos, r_rpos;

    // Controller state kept across items.
    logic                r_seen_first;
    logic [31:0]         r_last_time;
    logic [DELTA_W-1:0]  r_prev_lpos, r_prev_rpos;
    logic [31:0]         r_error_sum;
    logic [15:0]         r_last_error;
    logic [7:0]          r_left_adjust, r_right_adjust;
    logic [7:0]          r_last_left_out, r_last_right_out;

    // Working registers of one update.
    logic [MAG_W-1:0]  r_lmag, r_rmag;
    logic              r_ldir_neg, r_rdir_neg;
    logic [15:0]       r_ms;
    logic [15:0]       r_num_mag;
    logic              r_num_neg;
    logic [15:0]       r_diff;
    logic [16:0]       r_delta;
    logic [14:0]       r_adj;
    logic              r_res_upd, r_res_lw, r_res_rw;

    // Output register.
    logic              r_out_valid;
    logic              r_out_upd, r_out_lw, r_out_rw;
    logic [7:0]        r_out_ls, r_out_rs;

    // Serial units.
    t_mac_cmd          mac_cmd;
    logic [ACC_W-1:0]  mac_mcand;
    logic [MPLR_W-1:0] mac_mplier;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_busy;
    t_div_cmd          div_cmd;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [QUO_W-1:0]  div_quo;
    logic              div_busy;

    // Datapath values.
    logic [31:0]        n_dt;
    logic               n_early;
    logic [DELTA_W-1:0] n_dl, n_dr;
    logic [MAG_W-1:0]   n_lmag, n_rmag;
    logic [15:0]        n_ms;
    logic [10:0]        n_tb_abs;
    logic [12:0]        n_bias;
    logic [17:0]        n_num;
    logic [17:0]        n_num_abs;
    logic [15:0]        n_diff;
    logic [31:0]        n_error_sum;
    logic [16:0]        n_delta;
    logic [ACC_W-1:0]   n_acc_abs;
    logic [15:0]        n_p;
    logic [16:0]        n_adj17;
    logic [16:0]        n_lsum, n_rsum;
    logic [7:0]         n_left_adjust, n_right_adjust;
    logic [16:0]        n_lspd, n_rspd;
    logic [7:0]         n_ls, n_rs;
    logic               n_out_load;

    wsp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mac_cmd),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    wsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_busy     (div_busy)
    );

    always_comb begin
        n_dt    = r_now - r_last_time;
        n_early = (n_dt < MIN_INTERVAL);
        n_dl    = r_lpos - r_prev_lpos;
        n_dr    = r_rpos - r_prev_rpos;
        // A zero delta counts as forward.
        n_lmag  = n_dl[DELTA_W-1] ? (MAG_W'(0) - {1'b1, n_dl}) : {1'b0, n_dl};
        n_rmag  = n_dr[DELTA_W-1] ? (MAG_W'(0) - {1'b1, n_dr}) : {1'b0, n_dr};
        n_ms    = (n_dt[31:16] != '0) ? 16'hFFFF : n_dt[15:0];

        n_tb_abs = r_tick_bias[10] ? (11'd0 - r_tick_bias) : r_tick_bias;
        n_bias   = r_tick_bias[10] ? (13'd0 - {1'b0, div_quo[11:0]})
                                   : {1'b0, div_quo[11:0]};
        n_num     = {1'b0, r_lmag} - {1'b0, r_rmag} + {{5{n_bias[12]}}, n_bias};
        n_num_abs = n_num[17] ? (18'd0 - n_num) : n_num;

        n_diff      = r_num_neg ? (16'd0 - {1'b0, div_quo[14:0]})
                                : {1'b0, div_quo[14:0]};
        n_error_sum = r_error_sum + {{16{n_diff[15]}}, n_diff};
        n_delta     = {n_diff[15], n_diff} - {r_last_error[15], r_last_error};

        n_acc_abs = mac_acc[ACC_W-1] ? (ACC_W'(0) - mac_acc) : mac_acc;
        n_p       = mac_acc[ACC_W-1] ? (16'd0 - div_quo) : div_quo;

        n_adj17 = {{2{r_adj[14]}}, r_adj};
        n_lsum  = r_ldir_neg ? ({{9{r_left_adjust[7]}}, r_left_adjust} + n_adj17)
                             : ({{9{r_left_adjust[7]}}, r_left_adjust} - n_adj17);
        n_rsum  = r_rdir_neg ? ({{9{r_right_adjust[7]}}, r_right_adjust} - n_adj17)
                             : ({{9{r_right_adjust[7]}}, r_right_adjust} + n_adj17);
        n_left_adjust  = f_clamp($signed(n_lsum), r_adjust_limit);
        n_right_adjust = f_clamp($signed(n_rsum), r_adjust_limit);

        n_lspd = {{9{r_base_left[7]}}, r_base_left}
               + {{9{r_left_adjust[7]}}, r_left_adjust};
        n_rspd = {{9{r_base_right[7]}}, r_base_right}
               + {{9{r_right_adjust[7]}}, r_right_adjust};
        n_ls   = f_clamp($signed(n_lspd), r_speed_limit);
        n_rs   = f_clamp($signed(n_rspd), r_speed_limit);

        n_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_CHECK;
            S_CHECK:      n_state = (!r_seen_first || n_early) ? S_OUT : S_BIAS_MUL;
            S_BIAS_MUL:   n_state = S_BIAS_MUL_W;
            S_BIAS_MUL_W: if (!mac_busy) n_state = S_BIAS_DIV;
            S_BIAS_DIV:   n_state = S_BIAS_DIV_W;
            S_BIAS_DIV_W: if (!div_busy) n_state = S_RATE_MUL;
            S_RATE_MUL:   n_state = S_RATE_MUL_W;
            S_RATE_MUL_W: if (!mac_busy) n_state = S_RATE_DIV;
            S_RATE_DIV:   n_state = S_RATE_DIV_W;
            S_RATE_DIV_W: if (!div_busy) n_state = S_PID_P;
            S_PID_P:      n_state = S_PID_P_W;
            S_PID_P_W:    if (!mac_busy) n_state = S_PID_I;
            S_PID_I:      n_state = S_PID_I_W;
            S_PID_I_W:    if (!mac_busy) n_state = S_PID_D;
            S_PID_D:      n_state = S_PID_D_W;
            S_PID_D_W:    if (!mac_busy) n_state = S_GAIN_DIV;
            S_GAIN_DIV:   n_state = S_GAIN_DIV_W;
            S_GAIN_DIV_W: if (!div_busy) n_state = S_ADJUST;
            S_ADJUST:     n_state = S_SPEED;
            S_SPEED:      n_state = S_OUT;
            S_OUT:        if (n_out_load) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Commands and operands of the serial units.
    always_comb begin
        mac_cmd      = '0;
        mac_mcand    = '0;
        mac_mplier   = '0;
        div_cmd      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_BIAS_MUL: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_mcand     = {{(ACC_W-MAG_W){1'b0}}, r_rmag};
                mac_mplier    = {{(MPLR_W-11){1'b0}}, n_tb_abs};
            end
            S_BIAS_DIV: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(BIAS_BITS);
                div_dividend  = {mac_acc[BIAS_BITS-1:0], {(DVD_W-BIAS_BITS){1'b0}}};
                div_divisor   = BIAS_SCALE;
            end
            S_RATE_MUL: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_mcand     = {{(ACC_W-16){1'b0}}, r_num_mag};
                mac_mplier    = RATE_SCALE;
            end
            S_RATE_DIV: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(RATE_BITS);
                div_dividend  = {mac_acc[RATE_BITS-1:0], {(DVD_W-RATE_BITS){1'b0}}};
                div_divisor   = r_ms;
            end
            S_PID_P: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_mcand     = {{(ACC_W-16){r_diff[15]}}, r_diff};
                mac_mplier    = r_gain_p;
            end
            S_PID_I: begin
                mac_cmd.start = 1'b1;
                mac_mcand     = {{(ACC_W-32){r_error_sum[31]}}, r_error_sum};
                mac_mplier    = r_gain_i;
            end
            S_PID_D: begin
                mac_cmd.start = 1'b1;
                mac_mcand     = {{(ACC_W-17){r_delta[16]}}, r_delta};
                mac_mplier    = r_gain_d;
            end
            S_GAIN_DIV: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(GAIN_BITS);
                div_dividend  = n_acc_abs[GAIN_BITS-1:0];
                div_divisor   = GAIN_SCALE;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= RST_GAIN_P;
            r_gain_i       <= RST_GAIN_I;
            r_gain_d       <= RST_GAIN_D;
            r_tick_bias    <= RST_TICK_BIAS;
            r_adjust_limit <= RST_ADJUST_LIMIT;
            r_speed_limit  <= RST_SPEED_LIMIT;
            r_base_left    <= RST_BASE_SPEED;
            r_base_right   <= RST_BASE_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_P:       r_gain_p       <= i_cfg_data;
                CFG_GAIN_I:       r_gain_i       <= i_cfg_data;
                CFG_GAIN_D:       r_gain_d       <= i_cfg_data;
                CFG_TICK_BIAS:    r_tick_bias    <= i_cfg_data[10:0];
                CFG_ADJUST_LIMIT: r_adjust_limit <= i_cfg_data[6:0];
                CFG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_data[6:0];
                CFG_BASE_LEFT:    r_base_left    <= i_cfg_data[7:0];
                CFG_BASE_RIGHT:   r_base_right   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state that persists from one item to the next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first     <= 1'b0;
            r_last_time      <= '0;
            r_prev_lpos      <= '0;
            r_prev_rpos      <= '0;
            r_error_sum      <= '0;
            r_last_error     <= '0;
            r_left_adjust    <= '0;
            r_right_adjust   <= '0;
            r_last_left_out  <= '0;
            r_last_right_out <= '0;
        end else begin
            case (r_state)
                S_CHECK: begin
                    if (!r_seen_first) begin
                        r_seen_first <= 1'b1;
                        r_last_time  <= r_now;
                    end else if (!n_early) begin
                        r_last_time <= r_now;
                        r_prev_lpos <= r_lpos;
                        r_prev_rpos <= r_rpos;
                    end
                end
                S_RATE_DIV_W: begin
                    if (!div_busy) begin
                        r_error_sum  <= n_error_sum;
                        r_last_error <= n_diff;
                    end
                end
                S_ADJUST: begin
                    r_left_adjust  <= n_left_adjust;
                    r_right_adjust <= n_right_adjust;
                end
                S_SPEED: begin
                    r_last_left_out  <= n_ls;
                    r_last_right_out <= n_rs;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_now  <= i_time_ms;
                r_lpos <= i_left_position[DELTA_W-1:0];
                r_rpos <= i_right_position[DELTA_W-1:0];
            end
            S_CHECK: begin
                r_lmag     <= n_lmag;
                r_rmag     <= n_rmag;
                r_ldir_neg <= n_dl[DELTA_W-1];
                r_rdir_neg <= n_dr[DELTA_W-1];
                r_ms       <= n_ms;
                r_res_upd  <= 1'b0;
                r_res_lw   <= 1'b0;
                r_res_rw   <= 1'b0;
            end
            S_BIAS_DIV_W: begin
                if (!div_busy) begin
                    r_num_mag <= n_num_abs[15:0];
                    r_num_neg <= n_num[17];
                end
            end
            S_RATE_DIV_W: begin
                if (!div_busy) begin
                    r_diff  <= n_diff;
                    r_delta <= n_delta;
                end
            end
            S_GAIN_DIV_W: begin
                // Floor of half the wrapped PID output.
                if (!div_busy) begin
                    r_adj <= n_p[15:1];
                end
            end
            S_SPEED: begin
                r_res_upd <= 1'b1;
                r_res_lw  <= (n_ls != r_last_left_out);
                r_res_rw  <= (n_rs != r_last_right_out);
            end
            default: begin
            end
        endcase
    end

    // Output register: holds one result until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out_upd <= r_res_upd;
            r_out_lw  <= r_res_lw;
            r_out_rw  <= r_res_rw;
            r_out_ls  <= r_res_upd ? r_last_left_out : 8'd0;
            r_out_rs  <= r_res_upd ? r_last_right_out : 8'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_updated     = r_out_upd;
    assign o_left_speed  = r_out_ls;
    assign o_right_speed = r_out_rs;
    assign o_left_write  = r_out_lw;
    assign o_right_write = r_out_rw;

`ifndef SYNTHESIS
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mac_busy && div_busy))
        else $error("multiplier and divider busy at the same time");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_updated) |->
            (o_left_speed == 8'sd0 && o_right_speed == 8'sd0 &&
             !o_left_write && !o_right_write))
        else $error("result without update carries nonzero fields");

    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_updated) |->
            ($signed(o_left_speed) <= $signed({1'b0, r_speed_limit}) &&
             $signed(o_left_speed) >= -$signed({1'b0, r_speed_limit}) &&
             $signed(o_right_speed) <= $signed({1'b0, r_speed_limit}) &&
             $signed(o_right_speed) >= -$signed({1'b0, r_speed_limit})))
        else $error("commanded speed outside the speed limit");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> o_out_valid)
        else $error("finished result not presented");
`endif

endmodule

FILE: dv/wheel_sync_checker.sv
module wheel_sync_checker
    import wsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [31:0]           i_time_ms,
    input  logic [31:0]           i_left_position,
    input  logic [31:0]           i_right_position,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_updated,
    input  logic signed [7:0]     i_left_speed,
    input  logic signed [7:0]     i_right_speed,
    input  logic                  i_left_write,
    input  logic                  i_right_write,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              updated;
        logic signed [7:0] left_speed;
        logic signed [7:0] right_speed;
        logic              left_write;
        logic              right_write;
    } t_speed_cmd;

    t_speed_cmd expected_cmds[$];

    // Register copies, updated from the write port.
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [10:0] tick_bias;
    logic [6:0]         adjust_limit;
    logic [6:0]         speed_limit;
    logic signed [7:0]  base_left;
    logic signed [7:0]  base_right;

    // Controller state. Only the low 16 bits of a position reach the deltas.
    logic               seen_first;
    logic [31:0]        last_time;
    logic [15:0]        prev_left;
    logic [15:0]        prev_right;
    logic signed [31:0] error_sum;
    logic signed [15:0] last_error;
    logic signed [7:0]  left_adjust;
    logic signed [7:0]  right_adjust;
    logic signed [7:0]  last_left_out;
    logic signed [7:0]  last_right_out;

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic t_speed_cmd sync_wheels(input logic [31:0] now,
                                               input logic [15:0] lpos,
                                               input logic [15:0] rpos);
        t_speed_cmd         cmd;
        logic [31:0]        dt;
        logic signed [15:0] dl;
        logic signed [15:0] dr;
        logic signed [15:0] pid16;
        longint             ldir, rdir, lm, rm, ms, bias, diff, delta, pid, adj, ls, rs;
        cmd = '0;
        if (!seen_first) begin
            seen_first = 1'b1;
            last_time  = now;
            return cmd;
        end
        dt = now - last_time;
        if (dt < MIN_INTERVAL) begin
            return cmd;
        end
        dl = lpos - prev_left;
        dr = rpos - prev_right;
        prev_left  = lpos;
        prev_right = rpos;
        last_time  = now;
        ms = (dt > 32'd65535) ? 65535 : longint'(dt);

        // A zero delta counts as forward motion.
        ldir = (dl < 0) ? -1 : 1;
        rdir = (dr < 0) ? -1 : 1;
        lm = longint'(dl) * ldir;
        rm = longint'(dr) * rdir;

        bias = (rm * longint'(tick_bias)) / 10000;
        diff = ((lm - rm + bias) * 100) / ms;
        error_sum = 32'(longint'(error_sum) + diff);
        delta = diff - longint'(last_error);
        pid = (longint'(gain_p) * diff + longint'(gain_i) * longint'(error_sum)
               + longint'(gain_d) * delta) / 1000;
        pid16 = 16'(pid);
        last_error = 16'(diff);

        // Halving rounds toward minus infinity.
        adj = longint'(pid16) >>> 1;
        left_adjust  = 8'(clamp_to(longint'(left_adjust) - adj * ldir,
                                   longint'(adjust_limit)));
        right_adjust = 8'(clamp_to(longint'(right_adjust) + adj * rdir,
                                   longint'(adjust_limit)));
        ls = clamp_to(longint'(base_left) + longint'(left_adjust), longint'(speed_limit));
        rs = clamp_to(longint'(base_right) + longint'(right_adjust), longint'(speed_limit));

        cmd.updated     = 1'b1;
        cmd.left_speed  = 8'(ls);
        cmd.right_speed = 8'(rs);
        cmd.left_write  = (8'(ls) != last_left_out);
        cmd.right_write = (8'(rs) != last_right_out);
        last_left_out   = 8'(ls);
        last_right_out  = 8'(rs);
        return cmd;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_speed_cmd want;
        if (!i_rst_n) begin
            gain_p         = RST_GAIN_P;
            gain_i         = RST_GAIN_I;
            gain_d         = RST_GAIN_D;
            tick_bias      = RST_TICK_BIAS;
            adjust_limit   = RST_ADJUST_LIMIT;
            speed_limit    = RST_SPEED_LIMIT;
            base_left      = RST_BASE_SPEED;
            base_right     = RST_BASE_SPEED;
            seen_first     = 1'b0;
            last_time      = '0;
            prev_left      = '0;
            prev_right     = '0;
            error_sum      = '0;
            last_error     = '0;
            left_adjust    = '0;
            right_adjust   = '0;
            last_left_out  = '0;
            last_right_out = '0;
            expected_cmds.delete();
            o_mismatches   = 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:       gain_p       = i_cfg_data;
                    CFG_GAIN_I:       gain_i       = i_cfg_data;
                    CFG_GAIN_D:       gain_d       = i_cfg_data;
                    CFG_TICK_BIAS:    tick_bias    = i_cfg_data[10:0];
                    CFG_ADJUST_LIMIT: adjust_limit = i_cfg_data[6:0];
                    CFG_SPEED_LIMIT:  speed_limit  = i_cfg_data[6:0];
                    CFG_BASE_LEFT:    base_left    = i_cfg_data[7:0];
                    CFG_BASE_RIGHT:   base_right   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Results are matched before the new item is queued, so a result can never
            // pair with an item taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_cmds.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    o_mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("updated", int'(want.updated), int'(i_updated));
                    check_field("left_speed", int'(want.left_speed), int'(i_left_speed));
                    check_field("right_speed", int'(want.right_speed), int'(i_right_speed));
                    check_field("left_write", int'(want.left_write), int'(i_left_write));
                    check_field("right_write", int'(want.right_write), int'(i_right_write));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_cmds.push_back(sync_wheels(i_time_ms, i_left_position[15:0],
                                                    i_right_position[15:0]));
            end
            o_outstanding <= expected_cmds.size();
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [31:0]           i_time_ms        = '0;
    logic [31:0]           i_left_position  = '0;
    logic [31:0]           i_right_position = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic                  o_updated;
    logic signed [7:0]     o_left_speed;
    logic signed [7:0]     o_right_speed;
    logic                  o_left_write;
    logic                  o_right_write;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    int mismatches;
    int outstanding;

    // Stimulus knobs: idle and stall chances in percent per cycle, and a receiver hold-off request.
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;

    logic [31:0] cur_time;
    logic [31:0] cur_left;
    logic [31:0] cur_right;

    wheel_sync_pid DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_time_ms        (i_time_ms),
        .i_left_position  (i_left_position),
        .i_right_position (i_right_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_updated        (o_updated),
        .o_left_speed     (o_left_speed),
        .o_right_speed    (o_right_speed),
        .o_left_write     (o_left_write),
        .o_right_write    (o_right_write),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    wheel_sync_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_time_ms        (i_time_ms),
        .i_left_position  (i_left_position),
        .i_right_position (i_right_position),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_updated        (o_updated),
        .i_left_speed     (o_left_speed),
        .i_right_speed    (o_right_speed),
        .i_left_write     (o_left_write),
        .i_right_write    (o_right_write),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    task automatic send_item(input logic [31:0] t, input logic [31:0] l,
                             input logic [31:0] r);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_time_ms        <= t;
        i_left_position  <= l;
        i_right_position <= r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic step_item(input logic [31:0] dt, input int dl, input int dr);
        cur_time  = cur_time + dt;
        cur_left  = cur_left + dl;
        cur_right = cur_right + dr;
        send_item(cur_time, cur_left, cur_right);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 16'(value);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          pick;
        int          ticks;
        int          dl;
        int          dr;
        int          gain_top;
        logic [31:0] dt;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first item only records the time; its positions are never used.
        cur_time  = 32'hFFFF_FF00;
        cur_left  = 32'h7FFF_FFFF;
        cur_right = 32'h8000_0000;
        send_item(cur_time, cur_left, cur_right);
        step_item(199, 0, 0);
        // First update, exactly at the interval, deltas taken against zero.
        step_item(1, 1, -1);
        step_item(250, 32767, -32768);
        step_item(65535, 0, 0);
        step_item(65536, 120, 100);
        step_item(32'h8000_0000, -500, -480);
        step_item(0, 10, 10);
        step_item(200, -32768, 32767);
        // A steady lead on one side drives the adjustments into their clamp.
        repeat (8) step_item(200, 900, 300);
        repeat (4) step_item(200, 300, 900);
        step_item(200, 0, 0);

        for (int p = 0; p < 8; p++) begin
            drain();
            if (p == 1) begin
                write_reg(CFG_GAIN_P, 65535);
                write_reg(CFG_GAIN_I, 65535);
                write_reg(CFG_GAIN_D, 65535);
                write_reg(CFG_TICK_BIAS, 1000);
                write_reg(CFG_ADJUST_LIMIT, 127);
                write_reg(CFG_SPEED_LIMIT, 127);
                write_reg(CFG_BASE_LEFT, 100);
                write_reg(CFG_BASE_RIGHT, -100);
                i_cfg_we <= 1'b0;
            end else if (p == 2) begin
                write_reg(CFG_GAIN_P, 0);
                write_reg(CFG_GAIN_I, 0);
                write_reg(CFG_GAIN_D, 0);
                write_reg(CFG_TICK_BIAS, -1000);
                write_reg(CFG_ADJUST_LIMIT, 0);
                write_reg(CFG_SPEED_LIMIT, 0);
                write_reg(CFG_BASE_LEFT, -100);
                write_reg(CFG_BASE_RIGHT, 100);
                i_cfg_we <= 1'b0;
            end else if (p > 2) begin
                gain_top = $urandom_range(1) ? 65535 : 3000;
                write_reg(CFG_GAIN_P, $urandom_range(gain_top));
                write_reg(CFG_GAIN_I, $urandom_range(gain_top));
                write_reg(CFG_GAIN_D, $urandom_range(gain_top));
                write_reg(CFG_TICK_BIAS, int'($urandom_range(2000)) - 1000);
                write_reg(CFG_ADJUST_LIMIT, $urandom_range(127));
                write_reg(CFG_SPEED_LIMIT, $urandom_range(127));
                write_reg(CFG_BASE_LEFT, int'($urandom_range(200)) - 100);
                write_reg(CFG_BASE_RIGHT, int'($urandom_range(200)) - 100);
                i_cfg_we <= 1'b0;
            end

            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 62; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 62; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase

            for (int n = 0; n < 235; n++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    dt = $urandom_range(199);
                end else if (pick < 11) begin
                    dt = $urandom;
                end else if (pick < 15) begin
                    dt = $urandom_range(70000, 60000);
                end else begin
                    dt = $urandom_range(1200, 200);
                end

                pick = $urandom_range(99);
                if (pick < 6) begin
                    dl = $urandom;
                    dr = $urandom;
                end else if (pick < 12) begin
                    dl = int'($urandom_range(65535)) - 32768;
                    dr = int'($urandom_range(65535)) - 32768;
                end else begin
                    // Both wheels turning at nearly the same rate, as in normal driving.
                    ticks = $urandom_range(3000);
                    dl = ticks + int'($urandom_range(80)) - 40;
                    dr = ticks + int'($urandom_range(80)) - 40;
                    if ($urandom_range(9) == 0) begin
                        dl = -dl;
                    end
                    if ($urandom_range(9) == 0) begin
                        dr = -dr;
                    end
                    if ($urandom_range(4) == 0) begin
                        dl = -dl;
                        dr = -dr;
                    end
                end
                step_item(dt, dl, dr);

                // Hold the receiver off long enough that the block backs up its input.
                if (p == 4 && n == 60) begin
                    hold_req = 1500;
                end
                if (p == 2 && n == 120) begin
                    drain();
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/wsp_pkg.sv
rtl/wsp_mac.sv
rtl/wsp_div.sv
rtl/wheel_sync_pid.sv
dv/wheel_sync_checker.sv
dv/testbench.sv
